/* src/kbs_pkg.sv */
// Package of the keyed byte substitution block: sizes, request codes and the
// builder-to-memory control struct.
// Depends on nothing; every other file of the block but kbs_ram uses it.
package kbs_pkg;

    localparam int TableDepth = 256;
    localparam int ByteW      = 8;
    localparam int ReqW       = 2;

    // Request codes.
    localparam logic [ReqW-1:0] REQ_WRITE_KEY = 2'd0;
    localparam logic [ReqW-1:0] REQ_BUILD     = 2'd1;
    localparam logic [ReqW-1:0] REQ_FORWARD   = 2'd2;
    localparam logic [ReqW-1:0] REQ_INVERSE   = 2'd3;

    // Memory requests and status from the table builder.
    typedef struct packed {
        logic [ByteW-1:0] key_raddr;
        logic [ByteW-1:0] fwd_raddr;
        logic             fwd_we;
        logic [ByteW-1:0] fwd_waddr;
        logic [ByteW-1:0] fwd_wdata;
        logic             inv_we;
        logic [ByteW-1:0] inv_waddr;
        logic [ByteW-1:0] inv_wdata;
        logic             busy;
        logic             built;
    } bld_ctrl_t;

endpackage

/* src/kbs_req_if.sv */
// Request channel of the keyed byte substitution block: valid, ready and payload.
// Depends on kbs_pkg.
interface kbs_req_if;
    logic                       valid;
    logic                       ready;
    logic [kbs_pkg::ReqW-1:0]   req_type;
    logic [kbs_pkg::ByteW-1:0]  key_index;
    logic [kbs_pkg::ByteW-1:0]  key_byte;
    logic [kbs_pkg::ByteW-1:0]  data_byte;

    modport source (output valid, output req_type, output key_index,
                    output key_byte, output data_byte, input ready);
    modport sink   (input valid, input req_type, input key_index,
                    input key_byte, input data_byte, output ready);
endinterface

/* src/kbs_rsp_if.sv */
// Result channel of the keyed byte substitution block: valid, ready and payload.
// Depends on kbs_pkg.
interface kbs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [kbs_pkg::ByteW-1:0]  result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

/* src/kbs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module kbs_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/kbs_builder.sv */
// Table builder: identity fill, keyed swap pass and inverse fill, sequenced
// over the key, forward and inverse memories. Depends on kbs_pkg.
module kbs_builder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kbs_pkg::ByteW-1:0]  key_q,
    input  logic [kbs_pkg::ByteW-1:0]  fwd_q,
    output kbs_pkg::bld_ctrl_t         ctrl
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_KEY   = 4'd2;
    localparam logic [3:0] ST_RDI   = 4'd3;
    localparam logic [3:0] ST_RDJ   = 4'd4;
    localparam logic [3:0] ST_WR1   = 4'd5;
    localparam logic [3:0] ST_WR2   = 4'd6;
    localparam logic [3:0] ST_FILL  = 4'd7;
    localparam logic [3:0] ST_FILLW = 4'd8;

    localparam logic [kbs_pkg::ByteW-1:0] LastIdx = kbs_pkg::ByteW'(kbs_pkg::TableDepth - 1);

    logic [3:0]                state_reg, state_next;
    logic [kbs_pkg::ByteW-1:0] idx_reg, idx_next;
    logic [kbs_pkg::ByteW-1:0] j_reg, j_next;
    logic [kbs_pkg::ByteW-1:0] t_reg, t_next;
    logic                      built_reg, built_next;
    logic                      last;

    assign last = (idx_reg == LastIdx);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        t_next         = t_reg;
        built_next     = built_reg;
        ctrl           = '0;
        ctrl.key_raddr = idx_reg;
        ctrl.fwd_raddr = idx_reg;
        ctrl.busy      = (state_reg != ST_IDLE);
        ctrl.built     = built_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_INIT;
                    idx_next   = '0;
                end
            end
            ST_INIT:
            begin
                ctrl.fwd_we    = 1'b1;
                ctrl.fwd_waddr = idx_reg;
                ctrl.fwd_wdata = idx_reg;
                idx_next       = idx_reg + 1'b1;
                if (last)
                begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                state_next = ST_RDI;
            end
            ST_RDI:
            begin
                // Key byte for this position has arrived; fetch entry i.
                j_next     = key_q;
                state_next = ST_RDJ;
            end
            ST_RDJ:
            begin
                t_next         = fwd_q;
                ctrl.fwd_raddr = j_reg;
                state_next     = ST_WR1;
            end
            ST_WR1:
            begin
                ctrl.fwd_we    = 1'b1;
                ctrl.fwd_waddr = idx_reg;
                ctrl.fwd_wdata = fwd_q;
                state_next     = ST_WR2;
            end
            ST_WR2:
            begin
                ctrl.fwd_we    = 1'b1;
                ctrl.fwd_waddr = j_reg;
                ctrl.fwd_wdata = t_reg;
                idx_next       = idx_reg + 1'b1;
                state_next     = last ? ST_FILL : ST_KEY;
            end
            ST_FILL:
            begin
                state_next = ST_FILLW;
            end
            ST_FILLW:
            begin
                ctrl.inv_we    = 1'b1;
                ctrl.inv_waddr = fwd_q;
                ctrl.inv_wdata = idx_reg;
                idx_next       = idx_reg + 1'b1;
                if (last)
                begin
                    state_next = ST_IDLE;
                    built_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            built_reg <= built_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        t_reg <= t_next;
    end

endmodule

/* src/kbs_out_fifo.sv */
// Two-entry result queue that drives the result channel.
// Depends on kbs_pkg and kbs_rsp_if.
module kbs_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [kbs_pkg::ByteW-1:0]  push_data,
    output logic                       pop,
    output logic [1:0]                 count,
    kbs_rsp_if.source                  rsp
);

    logic [kbs_pkg::ByteW-1:0] mem_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                count_reg, count_next;

    assign rsp.valid       = (count_reg != 2'd0);
    assign rsp.result_byte = mem_reg[rd_ptr_reg];
    assign pop             = rsp.valid && rsp.ready;
    assign count           = count_reg;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/keyed_byte_substitution.sv */
// Keyed byte substitution, top level. Uses kbs_pkg, kbs_req_if, kbs_rsp_if,
// kbs_ram, kbs_builder and kbs_out_fifo.
//
// The block keeps a 256-byte key store and two 256-entry tables, a forward
// permutation and its inverse, each in its own single-write, single-read RAM
// with a registered read. A write-key beat stores one key byte. A build beat
// rebuilds the tables: the builder writes the identity into the forward table,
// runs the keyed swap pass with a key read, two forward reads and two
// write-backs per position, then fills the inverse table; req.ready is low
// throughout. Forward and inverse substitute beats are accepted one per cycle
// while no build runs and the result queue has room; each presents its table
// address in the cycle of acceptance, the table data lands in the next cycle
// and is pushed into a two-entry result queue, which presents it as a result
// beat on the result channel. A stalled sink holds back at most two results
// before req.ready drops. Until the first build has completed, both tables
// read as the identity, tracked by one flag rather than a clearing pass.
// Results leave in request order; a build starts only after earlier lookups
// have been read from the tables. Building from a key store position that
// was never written gives unspecified tables.
module keyed_byte_substitution (
    input  logic      clk,
    input  logic      rst_n,
    kbs_req_if.sink   req,
    kbs_rsp_if.source rsp
);

    kbs_pkg::bld_ctrl_t        bld;
    logic [kbs_pkg::ByteW-1:0] key_q;
    logic [kbs_pkg::ByteW-1:0] fwd_q;
    logic [kbs_pkg::ByteW-1:0] inv_q;
    logic [kbs_pkg::ByteW-1:0] fwd_raddr;

    logic                      accept;
    logic                      is_sub;
    logic                      start;
    logic                      key_we;
    logic                      space;
    logic                      pop;
    logic [1:0]                out_count;
    logic [kbs_pkg::ByteW-1:0] push_data;

    // Lookup stage: the table read is in flight.
    logic                      s1_valid_reg;
    logic                      s1_inv_reg;
    logic                      s1_ident_reg;
    logic [kbs_pkg::ByteW-1:0] s1_data_reg;

    // Accept only when the queue will have room for this beat's result once
    // the lookup in flight has landed.
    always_comb
    begin
        unique case (out_count)
            2'd0:    space = 1'b1;
            2'd1:    space = !s1_valid_reg || pop;
            2'd2:    space = !s1_valid_reg && pop;
            default: space = 1'b0;
        endcase
    end

    assign req.ready = !bld.busy && space;
    assign accept    = req.valid && req.ready;
    assign is_sub    = (req.req_type == kbs_pkg::REQ_FORWARD)
                    || (req.req_type == kbs_pkg::REQ_INVERSE);
    assign start     = accept && (req.req_type == kbs_pkg::REQ_BUILD);
    assign key_we    = accept && (req.req_type == kbs_pkg::REQ_WRITE_KEY);

    // The forward table's read port serves lookups when the builder is idle.
    assign fwd_raddr = bld.busy ? bld.fwd_raddr : req.data_byte;

    kbs_ram #(.Width(kbs_pkg::ByteW), .Depth(kbs_pkg::TableDepth)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (req.key_index),
        .wdata (req.key_byte),
        .raddr (bld.key_raddr),
        .rdata (key_q)
    );

    kbs_ram #(.Width(kbs_pkg::ByteW), .Depth(kbs_pkg::TableDepth)) u_fwd_ram (
        .clk   (clk),
        .we    (bld.fwd_we),
        .waddr (bld.fwd_waddr),
        .wdata (bld.fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_q)
    );

    kbs_ram #(.Width(kbs_pkg::ByteW), .Depth(kbs_pkg::TableDepth)) u_inv_ram (
        .clk   (clk),
        .we    (bld.inv_we),
        .waddr (bld.inv_waddr),
        .wdata (bld.inv_wdata),
        .raddr (req.data_byte),
        .rdata (inv_q)
    );

    kbs_builder u_builder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .key_q (key_q),
        .fwd_q (fwd_q),
        .ctrl  (bld)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && is_sub;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_inv_reg   <= (req.req_type == kbs_pkg::REQ_INVERSE);
        s1_ident_reg <= !bld.built;
        s1_data_reg  <= req.data_byte;
    end

    // Before the first build both tables are the identity.
    assign push_data = s1_ident_reg ? s1_data_reg : (s1_inv_reg ? inv_q : fwd_q);

    kbs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .count     (out_count),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // A lookup in flight never lands in a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_count == 2'd2) |-> !s1_valid_reg)
        else $error("result queue overflow");

    // An accepted build holds off requests from the next cycle on.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (bld.busy && !req.ready))
        else $error("build did not take over the tables");

    // The tables are never written while a lookup is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (!bld.fwd_we && !bld.inv_we))
        else $error("table write during lookup");
`endif

endmodule

/* tb/kbs_tb_pkg.sv */
// Scoreboard for the keyed byte substitution testbench: predicts each lookup and
// checks the result beats against it in order.
// Depends on kbs_pkg for sizes and request codes.
package kbs_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import kbs_pkg::*;

    class substitution_scoreboard;
        logic [ByteW-1:0] key_bytes [TableDepth];
        logic [ByteW-1:0] fwd_map   [TableDepth];
        logic [ByteW-1:0] inv_map   [TableDepth];
        logic [ByteW-1:0] expected_bytes [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      forward_count;
        int unsigned      inverse_count;
        int unsigned      key_write_count;
        int unsigned      build_count;

        function new();
            for (int i = 0; i < TableDepth; i++)
            begin
                key_bytes[i] = '0;
                fwd_map[i]   = ByteW'(i);
                inv_map[i]   = ByteW'(i);
            end
            mismatches      = 0;
            checked         = 0;
            forward_count   = 0;
            inverse_count   = 0;
            key_write_count = 0;
            build_count     = 0;
        endfunction

        // Identity, then the keyed swap pass, then the inverse fill.
        function void rebuild_permutation();
            logic [ByteW-1:0] held;
            int               partner;
            for (int i = 0; i < TableDepth; i++)
            begin
                fwd_map[i] = ByteW'(i);
            end
            for (int i = 0; i < TableDepth; i++)
            begin
                partner          = key_bytes[i];
                held             = fwd_map[i];
                fwd_map[i]       = fwd_map[partner];
                fwd_map[partner] = held;
            end
            for (int i = 0; i < TableDepth; i++)
            begin
                inv_map[fwd_map[i]] = ByteW'(i);
            end
        endfunction

        function void note_request(input logic [ReqW-1:0]  kind,
                                   input logic [ByteW-1:0] idx,
                                   input logic [ByteW-1:0] kb,
                                   input logic [ByteW-1:0] db);
            case (kind)
                REQ_WRITE_KEY:
                begin
                    key_bytes[idx] = kb;
                    key_write_count++;
                end
                REQ_BUILD:
                begin
                    rebuild_permutation();
                    build_count++;
                end
                REQ_FORWARD:
                begin
                    expected_bytes.push_back(fwd_map[db]);
                    forward_count++;
                end
                default:
                begin
                    expected_bytes.push_back(inv_map[db]);
                    inverse_count++;
                end
            endcase
        endfunction

        function void check_result(input logic [ByteW-1:0] got);
            logic [ByteW-1:0] want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got 0x%02h", $time, got);
            end
            else
            begin
                want = expected_bytes.pop_front();
                checked++;
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: result_byte mismatch, expected 0x%02h, got 0x%02h",
                             $time, want, got);
                end
            end
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
// Top of the keyed byte substitution testbench: clock, reset, stimulus, sink
// stalls, beat monitor and the end-of-run verdict.
// Depends on kbs_pkg, kbs_req_if, kbs_rsp_if, kbs_tb_pkg and the block itself.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import kbs_pkg::*;
    import kbs_tb_pkg::*;

    // Key patterns loaded before a build. Zero and all-ones are the extremes of
    // the key byte; identity leaves the forward table as the identity.
    typedef enum int {KEY_ZERO, KEY_ONES, KEY_IDENTITY, KEY_REVERSED, KEY_RANDOM} key_style_t;

    // Behaviors of the result sink, each held for a stretch of cycles.
    typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC, SINK_HELD} sink_mode_t;

    // The cycle limit leaves ample margin over the slowest correct run: about
    // 1500 beats with gaps, long sink stalls, and some ten builds.
    localparam int unsigned CycleLimit   = 1_000_000;
    localparam int          SegmentBeats = 50;
    localparam int          SettleCycles = 32;

    logic clk;
    logic rst_n;

    kbs_req_if req();
    kbs_rsp_if rsp();

    keyed_byte_substitution i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    substitution_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 1;
    sink_mode_t  sink_mode   = SINK_OPEN;
    int          sink_left   = 0;
    int unsigned sink_tick   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // The watchdog ends a run that hangs, for instance when the block never
    // raises req.ready again after a build or drops a result beat.
    initial
    begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, sb.expected_bytes.size());
        $display("Test completed with failures");
        $finish;
    end

    // Both channels are sampled at the rising edge. Values seen here are the
    // ones from before the edge, so acceptance does not depend on event order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                sb.note_request(req.req_type, req.key_index, req.key_byte, req.data_byte);
            end
            if (rsp.valid && rsp.ready)
            begin
                sb.check_result(rsp.result_byte);
            end
        end
    end

    // The sink switches between behaviors: always ready, mostly ready, rarely
    // ready, a fixed one-in-five pattern, and short stretches held low. Held
    // stretches fill the two-entry result queue and push back on req.ready.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 4));
            sink_left = (sink_mode == SINK_HELD) ? $urandom_range(1, 40)
                                                 : $urandom_range(16, 200);
        end
        else
        begin
            sink_left = sink_left - 1;
        end
        sink_tick = sink_tick + 1;
        case (sink_mode)
            SINK_OPEN:     rsp.ready <= 1'b1;
            SINK_MOSTLY:   rsp.ready <= ($urandom_range(0, 3) != 0);
            SINK_SPARSE:   rsp.ready <= ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: rsp.ready <= (sink_tick % 5 == 0);
            default:       rsp.ready <= 1'b0;
        endcase
    end

    // Bursts are mostly short, but one in four is long enough to give stretches
    // of back-to-back beats.
    function automatic int pick_burst();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    endfunction

    // Presents one request beat and holds it until accepted. When the current
    // burst runs out, valid drops for a random gap before the next beat, so a
    // valid that stays high is never lowered and raised in the same step.
    task automatic send_request(input logic [ReqW-1:0]  kind,
                                input logic [ByteW-1:0] idx,
                                input logic [ByteW-1:0] kb,
                                input logic [ByteW-1:0] db);
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.key_index <= idx;
        req.key_byte  <= kb;
        req.data_byte <= db;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = pick_burst();
        end
    endtask

    // Lookups carry random values in the key fields, which the block must ignore.
    task automatic send_lookup(input logic [ReqW-1:0] kind, input logic [ByteW-1:0] db);
        send_request(kind, ByteW'($urandom), ByteW'($urandom), db);
    endtask

    // The sender pauses until every outstanding lookup has returned. The first
    // edge also lets the monitor note a beat accepted at the previous edge.
    task automatic wait_for_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        burst_left = pick_burst();
    endtask

    // Writes all 256 key bytes in a scrambled order, so that no later build
    // ever reads a key position that was never written.
    task automatic load_key(input key_style_t style);
        logic [ByteW-1:0] base;
        logic [ByteW-1:0] idx;
        logic [ByteW-1:0] kb;
        base = ByteW'($urandom);
        for (int n = 0; n < TableDepth; n++)
        begin
            idx = ByteW'(n) ^ base;
            case (style)
                KEY_ZERO:     kb = '0;
                KEY_ONES:     kb = '1;
                KEY_IDENTITY: kb = idx;
                KEY_REVERSED: kb = ~idx;
                default:      kb = ByteW'($urandom);
            endcase
            send_request(REQ_WRITE_KEY, idx, kb, ByteW'($urandom));
        end
    endtask

    // Mostly lookups in both directions, with key writes that only take effect
    // at the next build and occasional builds, half of them after a drain.
    task automatic mixed_traffic(input int beats);
        int               pick;
        logic [ByteW-1:0] db;
        repeat (beats)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
            begin
                db = $urandom_range(0, 1) ? {ByteW{1'b1}} : {ByteW{1'b0}};
            end
            else
            begin
                db = ByteW'($urandom);
            end
            if (pick < 44)
            begin
                send_lookup(REQ_FORWARD, db);
            end
            else if (pick < 88)
            begin
                send_lookup(REQ_INVERSE, db);
            end
            else if (pick < 98)
            begin
                send_request(REQ_WRITE_KEY, ByteW'($urandom), ByteW'($urandom), db);
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    wait_for_results();
                end
                send_request(REQ_BUILD, ByteW'($urandom), ByteW'($urandom), db);
            end
        end
    endtask

    initial
    begin : stimulus
        key_style_t segment_styles [4];
        segment_styles = '{KEY_ONES, KEY_IDENTITY, KEY_REVERSED, KEY_RANDOM};

        // Every input is known from time zero; reset is held at the start of the run.
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.req_type  = REQ_WRITE_KEY;
        req.key_index = '0;
        req.key_byte  = '0;
        req.data_byte = '0;
        rsp.ready     = 1'b0;
        burst_left    = pick_burst();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before any build both tables are the identity, whatever the unused
        // fields hold.
        send_lookup(REQ_FORWARD, 8'h00);
        send_lookup(REQ_FORWARD, 8'hFF);
        send_lookup(REQ_INVERSE, 8'h00);
        send_lookup(REQ_INVERSE, 8'hFF);
        send_request(REQ_FORWARD, 8'hFF, 8'hFF, 8'hA5);
        send_request(REQ_INVERSE, 8'h00, 8'h00, 8'h5A);
        wait_for_results();

        // An all-zero key swaps every position with entry zero.
        load_key(KEY_ZERO);
        send_request(REQ_BUILD, 8'hFF, 8'hFF, 8'hFF);
        send_lookup(REQ_FORWARD, 8'h00);
        send_lookup(REQ_FORWARD, 8'hFF);
        send_lookup(REQ_INVERSE, 8'h00);
        send_lookup(REQ_INVERSE, 8'hFF);
        send_request(REQ_FORWARD, 8'h00, 8'h00, 8'h01);

        // Key writes after a build leave the tables alone until the next build.
        send_request(REQ_WRITE_KEY, 8'h00, 8'hFF, 8'h00);
        send_request(REQ_WRITE_KEY, 8'hFF, 8'h80, 8'hFF);
        send_lookup(REQ_FORWARD, 8'h00);
        send_lookup(REQ_INVERSE, 8'h00);
        send_lookup(REQ_FORWARD, 8'hFF);
        send_request(REQ_BUILD, 8'h00, 8'h00, 8'h00);
        send_lookup(REQ_FORWARD, 8'h00);
        send_lookup(REQ_INVERSE, 8'hFF);
        send_lookup(REQ_FORWARD, 8'h80);

        // Random part: each segment starts from a fresh full key and build.
        foreach (segment_styles[s])
        begin
            wait_for_results();
            load_key(segment_styles[s]);
            send_request(REQ_BUILD, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
            mixed_traffic(SegmentBeats);
        end

        wait_for_results();
        repeat (SettleCycles) @(posedge clk);

        $display("Covered %0d forward and %0d inverse lookups, %0d key writes, %0d builds.",
                 sb.forward_count, sb.inverse_count, sb.key_write_count, sb.build_count);
        $display("Checked %0d result beats across five key patterns, %0d mismatches.",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
src/kbs_pkg.sv
src/kbs_req_if.sv
src/kbs_rsp_if.sv
src/kbs_ram.sv
src/kbs_builder.sv
src/kbs_out_fifo.sv
src/keyed_byte_substitution.sv
tb/kbs_tb_pkg.sv
tb/tb_top.sv
